[rtl/core/cau_pkg.sv]
// Package: widths, op and status codes, pipeline cell payload type.
package cau_pkg;
  localparam int DW = 16;
  localparam int FB = 8;
  localparam int PW = 2 * DW;          // product width
  localparam int NW = PW + 2;          // signed sum of two products
  localparam int QW = DW + 1;          // quotient bits kept (enough to detect saturation)
  localparam int SQW = PW / 2 + 1;     // sqrt result width
  localparam int NCELL = QW;           // one quotient bit per cell; sqrt shares the row

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_ADDR = 3'd1, OP_MUL = 3'd2,
    OP_DIV = 3'd3, OP_CONJ = 3'd4, OP_MAG = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIVZ = 2'd1, ST_SAT = 2'd2
  } status_t;

  // Data handed from cell to cell.
  typedef struct packed {
    logic              vld;
    logic [2:0]        op;
    logic [DW-1:0]     fre;      // final result parts for non-iterative ops
    logic [DW-1:0]     fim;
    logic              fsat;
    logic              zden;
    logic              nre;      // quotient signs
    logic              nim;
    logic [NW+FB-1:0]  rre;      // partial remainders / sqrt radicand
    logic [NW+FB-1:0]  rim;
    logic [NW+FB-1:0]  den;
    logic [QW-1:0]     qre;      // quotient bits / sqrt root
    logic [QW-1:0]     qim;
  } cell_t;

  function automatic logic [DW-1:0] sat_s(input logic signed [NW+FB:0] v, inout logic s);
    logic signed [NW+FB:0] hi, lo;
    begin
      hi = (NW+FB+1)'((2**(DW-1)) - 1);
      lo = -(NW+FB+1)'(2**(DW-1));
      if (v > hi) begin s = 1'b1; sat_s = hi[DW-1:0]; end
      else if (v < lo) begin s = 1'b1; sat_s = lo[DW-1:0]; end
      else sat_s = v[DW-1:0];
    end
  endfunction
endpackage

[rtl/core/cau_if.sv]
// Valid/ready stream interface for operand and result transactions.
interface cau_in_if (input logic clk);
  logic              valid, ready;
  logic [2:0]        op;
  logic signed [cau_pkg::DW-1:0] a_re, a_im, b_re, b_im;
  modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
  modport sink (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if (input logic clk);
  logic              valid, ready;
  logic signed [cau_pkg::DW-1:0] res_re, res_im;
  logic [1:0]        status;
  modport source (output valid, res_re, res_im, status, input ready);
  modport sink (input valid, res_re, res_im, status, output ready);
endinterface

[rtl/core/cau_front.sv]
// Front stage: products, sums, and finished results for single-pass ops.
module cau_front (
  input  logic               clk,
  input  logic               en,
  input  logic               vld,
  input  logic [2:0]         op,
  input  logic signed [cau_pkg::DW-1:0] a_re, a_im, b_re, b_im,
  output cau_pkg::cell_t     cell_o
);
  import cau_pkg::*;
  logic signed [PW-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r, p_bb_r, p_cc_r;
  logic signed [NW-1:0] ar_r, ai_r, br_r, bi_r;
  logic [2:0] op_r;
  logic vld_r;
  cell_t c;
  logic signed [NW-1:0] nre, nim, nden;
  logic signed [NW+FB:0] xre, xim;
  logic s;

  // Stage A: one multiplier per product.
  always_ff @(posedge clk) begin
    if (en) begin
      vld_r <= vld; op_r <= op;
      p_rr_r <= a_re * b_re; p_ii_r <= a_im * b_im;
      p_ri_r <= a_re * b_im; p_ir_r <= a_im * b_re;
      p_bb_r <= (op == OP_MAG) ? a_re * a_re : b_re * b_re;
      p_cc_r <= (op == OP_MAG) ? a_im * a_im : b_im * b_im;
      ar_r <= NW'(a_re); ai_r <= NW'(a_im); br_r <= NW'(b_re); bi_r <= NW'(b_im);
    end
  end

  always_comb begin
    c = '0; s = 1'b0;
    c.vld = vld_r; c.op = op_r;
    nden = NW'(p_bb_r) + NW'(p_cc_r);
    xre = '0; xim = '0;
    case (op_r)
      OP_ADD:  begin xre = (NW+FB+1)'(ar_r + br_r); xim = (NW+FB+1)'(ai_r + bi_r); end
      OP_ADDR: begin xre = (NW+FB+1)'(ar_r + br_r); xim = (NW+FB+1)'(ai_r); end
      OP_MUL:  begin
        xre = (NW+FB+1)'((NW'(p_rr_r) - NW'(p_ii_r)) >>> FB);
        xim = (NW+FB+1)'((NW'(p_ri_r) + NW'(p_ir_r)) >>> FB);
      end
      OP_CONJ: begin xre = (NW+FB+1)'(ar_r); xim = -(NW+FB+1)'(ai_r); end
      default: ;
    endcase
    c.fre = sat_s(xre, s);
    c.fim = sat_s(xim, s);
    c.fsat = s;
    nre = NW'(p_rr_r) + NW'(p_ii_r);
    nim = NW'(p_ir_r) - NW'(p_ri_r);
    c.nre = nre[NW-1]; c.nim = nim[NW-1];
    c.zden = (nden == '0);
    if (op_r == OP_MAG) begin
      c.rre = (NW+FB)'(nden);
      c.den = '0;
    end else begin
      c.rre = {(nre[NW-1] ? -nre : nre), {FB{1'b0}}};
      c.rim = {(nim[NW-1] ? -nim : nim), {FB{1'b0}}};
      c.den = (NW+FB)'(nden);
    end
  end

  always_ff @(posedge clk) if (en) cell_o <= c;
endmodule

[rtl/core/cau_cell.sv]
// One cell: a restoring divide step on both parts, or one sqrt digit.
module cau_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [4:0]     idx,
  input  cau_pkg::cell_t cell_i,
  output cau_pkg::cell_t cell_o
);
  import cau_pkg::*;
  cell_t c;
  logic [NW+FB:0] t, tr, ti;
  logic [NW+FB-1:0] dsh;
  logic [NW+FB-1:0] bit_w;
  logic [5:0] sh;

  always_comb begin
    c = cell_i;
    sh = 6'(QW - 1) - 6'(idx);
    dsh = cell_i.den << sh;
    tr = '0; ti = '0; t = '0;
    bit_w = '0;
    if (cell_i.op == OP_MAG) begin
      // Root digit: cell idx decides root bit (SQW-1-idx); cells with idx >= SQW are idle.
      if (idx < 5'(SQW)) begin
        bit_w = (NW+FB)'(1) << (2 * (SQW - 1 - idx));
        t = {1'b0, cell_i.rre} - {1'b0, ((NW+FB)'(cell_i.qre) << (SQW - idx)) | bit_w};
        if (!t[NW+FB]) begin
          c.rre = t[NW+FB-1:0];
          c.qre = cell_i.qre | (QW'(1) << (SQW - 1 - idx));
        end
      end
    end else begin
      if (cell_i.den >> (NW+FB-1-sh) == '0 || sh == 0) begin
        tr = {1'b0, cell_i.rre} - {1'b0, dsh};
        ti = {1'b0, cell_i.rim} - {1'b0, dsh};
      end else begin
        tr = '1; ti = '1;
      end
      if (!tr[NW+FB]) begin c.rre = tr[NW+FB-1:0]; c.qre[sh[4:0]] = 1'b1; end
      if (!ti[NW+FB]) begin c.rim = ti[NW+FB-1:0]; c.qim[sh[4:0]] = 1'b1; end
    end
  end

  always_ff @(posedge clk) if (en) cell_o <= c;
endmodule

[rtl/core/complex_arithmetic_unit.sv]
// Operands pass through the front stage registers, the cell row and the output register.
// Throughput: one transaction per cycle while not stalled; the whole row advances together.
// The row is a quotient cell chain, one bit per cell; sqrt digits share it.
// Backpressure stalls the row only when the output register is full and not taken.
// Reset: synchronous active-low rst_n clears the v_r valid flags and the output valid; no clearing pass.
module complex_arithmetic_unit (
  input logic clk,
  input logic rst_n,
  cau_in_if.sink   in_ch,
  cau_out_if.source out_ch
);
  import cau_pkg::*;
  cell_t row [NCELL+1];
  logic en;
  logic [NCELL+1:0] v_r;
  logic ovld_r;
  logic [DW-1:0] ore_r, oim_r;
  logic [1:0] ost_r;
  logic [DW-1:0] dre, dim;
  logic s;
  logic [1:0] st;
  cell_t fin;

  assign en = !ovld_r || out_ch.ready;
  assign in_ch.ready = en;

  cau_front u_front (.clk, .en, .vld(in_ch.valid), .op(in_ch.op), .a_re(in_ch.a_re),
                     .a_im(in_ch.a_im), .b_re(in_ch.b_re), .b_im(in_ch.b_im),
                     .cell_o(row[0]));
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    cau_cell u_cell (.clk, .en, .idx(5'(g)), .cell_i(row[g]), .cell_o(row[g+1]));
  end

  // Valid flags travel alongside the row with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[NCELL:0], in_ch.valid};
  end

  always_comb begin
    fin = row[NCELL];
    s = 1'b0; st = ST_OK;
    dre = '0; dim = '0;
    case (fin.op)
      OP_DIV: begin
        if (fin.zden) st = ST_DIVZ;
        else begin
          dre = sat_s(fin.nre ? -(NW+FB+1)'(fin.qre) : (NW+FB+1)'(fin.qre), s);
          dim = sat_s(fin.nim ? -(NW+FB+1)'(fin.qim) : (NW+FB+1)'(fin.qim), s);
        end
      end
      OP_MAG: dre = sat_s((NW+FB+1)'(fin.qre), s);
      OP_ADD, OP_ADDR, OP_MUL, OP_CONJ: begin dre = fin.fre; dim = fin.fim; s = fin.fsat; end
      default: ;
    endcase
    if (st == ST_OK && s) st = ST_SAT;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ovld_r <= 1'b0;
    else if (en) ovld_r <= v_r[NCELL+1];
  end
  always_ff @(posedge clk) if (en) begin ore_r <= dre; oim_r <= dim; ost_r <= st; end

  assign out_ch.valid = ovld_r;
  assign out_ch.res_re = ore_r;
  assign out_ch.res_im = oim_r;
  assign out_ch.status = ost_r;
endmodule

[rtl/core/cau_checker.sv]
// Port-level checker for the complex arithmetic unit, bound to the top level.
module cau_checker (
  input logic clk, rst_n,
  input logic iv, ir, ov, ordy,
  input logic [1:0] st,
  input logic [15:0] rim
);
  import cau_pkg::*;

  a_stall: assert property (@(posedge clk) disable iff (!rst_n) ov && !ordy |=> ov)
    else $error("result dropped");
  a_st: assert property (@(posedge clk) disable iff (!rst_n)
    ov |-> (st == ST_OK || st == ST_DIVZ || st == ST_SAT))
    else $error("bad status");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n) !ov |-> ir)
    else $error("not ready with empty output");
  a_dz: assert property (@(posedge clk) disable iff (!rst_n) ov && st == ST_DIVZ |-> rim == 16'd0)
    else $error("divide by zero with nonzero result");
  // Hold an offered transaction until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n) iv && !ir |=> iv)
    else $error("transaction withdrawn before accept");
endmodule

bind complex_arithmetic_unit cau_checker u_chk (.clk(clk), .rst_n(rst_n),
  .iv(in_ch.valid), .ir(in_ch.ready), .ov(out_ch.valid), .ordy(out_ch.ready),
  .st(out_ch.status), .rim(out_ch.res_im));

[tb/complex_arithmetic_unit_test.sv]
// Self-checking testbench for the complex arithmetic unit: directed table, then random traffic.
`timescale 1ns / 100ps

module complex_arithmetic_unit_test;
  import cau_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam logic [15:0] MAXV = 16'h7FFF;
  localparam logic [15:0] MINV = 16'h8000;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic [1:0]         st;
  } cplx_res_t;

  typedef struct {
    logic [2:0]         op;
    logic signed [15:0] ar, ai, br, bi;
    bit                 typed;
    cplx_res_t          res;
  } vector_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   stall_pct = 0;
  int   idle_pct = 0;
  int   errors = 0;
  cplx_res_t pending_results[$];

  cau_in_if  in_ch (clk);
  cau_out_if out_ch (clk);

  complex_arithmetic_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  function automatic logic signed [15:0] clamp16(input longint v, inout bit sat);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return -16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic longint floor_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // Quotient of num * 2^8 / den, truncated toward zero.
  function automatic longint scaled_quot(input longint num, input longint den);
    longint m;
    m = (num < 0) ? -num : num;
    m = (m <<< FB) / den;
    return (num < 0) ? -m : m;
  endfunction

  function automatic cplx_res_t cplx_result(input logic [2:0] op,
      input logic signed [15:0] ar, ai, br, bi);
    cplx_res_t r;
    bit sat;
    longint xr, xi, yr, yi, den;
    r = '{re: '0, im: '0, st: ST_OK};
    sat = 1'b0;
    xr = ar;
    xi = ai;
    yr = br;
    yi = bi;
    case (op)
      OP_ADD: begin
        r.re = clamp16(xr + yr, sat);
        r.im = clamp16(xi + yi, sat);
      end
      OP_ADDR: begin
        r.re = clamp16(xr + yr, sat);
        r.im = clamp16(xi, sat);
      end
      OP_MUL: begin
        r.re = clamp16((xr * yr - xi * yi) >>> FB, sat);
        r.im = clamp16((xr * yi + xi * yr) >>> FB, sat);
      end
      OP_DIV: begin
        den = yr * yr + yi * yi;
        if (den == 0) begin
          r.st = ST_DIVZ;
        end else begin
          r.re = clamp16(scaled_quot(xr * yr + xi * yi, den), sat);
          r.im = clamp16(scaled_quot(xi * yr - xr * yi, den), sat);
        end
      end
      OP_CONJ: begin
        r.re = clamp16(xr, sat);
        r.im = clamp16(-xi, sat);
      end
      OP_MAG: r.re = clamp16(floor_sqrt(xr * xr + xi * xi), sat);
      default: ;
    endcase
    if (r.st == ST_OK && sat) r.st = ST_SAT;
    return r;
  endfunction

  function automatic logic [15:0] pick_operand();
    case ($urandom_range(9))
      0: return MAXV;
      1: return MINV;
      2: return 16'h0000;
      3, 4, 5: return 16'($signed($urandom_range(2048)) - 1024);
      default: return 16'($urandom);
    endcase
  endfunction

  // Queue the expectation, then, after random idle cycles, hold the transaction until it is taken.
  task automatic send_item(input logic [2:0] op, input logic signed [15:0] ar, ai, br, bi,
      input bit typed, input cplx_res_t res);
    pending_results.push_back(typed ? res : cplx_result(op, ar, ai, br, bi));
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.a_re <= ar;
    in_ch.a_im <= ai;
    in_ch.b_re <= br;
    in_ch.b_im <= bi;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  always @(posedge clk) begin
    out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result re=%0d im=%0d status=%0d",
               out_ch.res_re, out_ch.res_im, out_ch.status);
        errors++;
      end else begin
        cplx_res_t e;
        e = pending_results.pop_front();
        if (out_ch.res_re !== e.re) begin
          $error("res_re expected %0d actual %0d", e.re, out_ch.res_re);
          errors++;
        end
        if (out_ch.res_im !== e.im) begin
          $error("res_im expected %0d actual %0d", e.im, out_ch.res_im);
          errors++;
        end
        if (out_ch.status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, out_ch.status);
          errors++;
        end
      end
    end
  end

  vector_t directed [] = '{
    '{OP_ADD, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 1, '{16'sh0000, 16'sh0000, ST_OK}},
    '{OP_ADD, MAXV, MAXV, MAXV, MAXV, 1, '{MAXV, MAXV, ST_SAT}},
    '{OP_ADD, MINV, MINV, MINV, MINV, 1, '{MINV, MINV, ST_SAT}},
    '{OP_ADD, MINV, MAXV, MAXV, MINV, 1, '{-16'sd1, -16'sd1, ST_OK}},
    '{OP_ADDR, MAXV, 16'sh1234, 16'sh0001, MAXV, 1, '{MAXV, 16'sh1234, ST_SAT}},
    '{OP_ADDR, MINV, MINV, -16'sd1, 16'sh0000, 1, '{MINV, MINV, ST_SAT}},
    '{OP_ADDR, 16'sh0100, -16'sd5, 16'sh0200, 16'sh5555, 0, '{0, 0, 0}},
    '{OP_MUL, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000, 1, '{16'sh0100, 16'sh0000, ST_OK}},
    '{OP_MUL, MINV, MINV, MINV, MINV, 1, '{16'sh0000, MAXV, ST_SAT}},
    '{OP_MUL, -16'sd1, 16'sh0000, 16'sh0001, 16'sh0000, 0, '{0, 0, 0}},
    '{OP_MUL, MAXV, MINV, MAXV, MAXV, 0, '{0, 0, 0}},
    '{OP_DIV, 16'sh1234, 16'sh5678, 16'sh0000, 16'sh0000, 1, '{16'sh0000, 16'sh0000, ST_DIVZ}},
    '{OP_DIV, 16'sh0100, 16'sh0000, 16'sh0100, 16'sh0000, 1, '{16'sh0100, 16'sh0000, ST_OK}},
    '{OP_DIV, MINV, MINV, MINV, MINV, 0, '{0, 0, 0}},
    '{OP_DIV, MAXV, 16'sh0000, 16'sh0001, 16'sh0000, 0, '{0, 0, 0}},
    '{OP_DIV, -16'sd1, 16'sh0003, 16'sh0300, -16'sd7, 0, '{0, 0, 0}},
    '{OP_CONJ, 16'sh1234, MINV, 16'sh0000, 16'sh0000, 1, '{16'sh1234, MAXV, ST_SAT}},
    '{OP_CONJ, MINV, MAXV, MAXV, MINV, 1, '{MINV, -16'sh7FFF, ST_OK}},
    '{OP_MAG, 16'sh0300, 16'sh0400, 16'sh1111, 16'sh2222, 1, '{16'sh0500, 16'sh0000, ST_OK}},
    '{OP_MAG, MINV, MINV, 16'sh0000, 16'sh0000, 1, '{MAXV, 16'sh0000, ST_SAT}},
    '{OP_MAG, 16'sh0000, 16'sh0000, MAXV, MINV, 1, '{16'sh0000, 16'sh0000, ST_OK}},
    '{OP_MAG, -16'sd3, 16'sh0007, 16'sh0000, 16'sh0000, 0, '{0, 0, 0}},
    '{OP_SPARE6, MAXV, MINV, MAXV, MINV, 1, '{16'sh0000, 16'sh0000, ST_OK}},
    '{OP_SPARE7, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1, '{16'sh0000, 16'sh0000, ST_OK}}
  };

  initial begin
    logic [2:0] op;
    logic signed [15:0] ar, ai, br, bi;
    int idle_mix [4] = '{0, 75, 0, 23};
    int stall_mix [4] = '{0, 0, 75, 23};
    in_ch.valid = 1'b0;
    in_ch.op = OP_ADD;
    in_ch.a_re = '0;
    in_ch.a_im = '0;
    in_ch.b_re = '0;
    in_ch.b_im = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i])
      send_item(directed[i].op, directed[i].ar, directed[i].ai, directed[i].br,
                directed[i].bi, directed[i].typed, directed[i].res);
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_mix[ph];
      stall_pct = stall_mix[ph];
      for (int n = 0; n < 500; n++) begin
        op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
        ar = pick_operand();
        ai = pick_operand();
        br = pick_operand();
        bi = pick_operand();
        // Force a zero divisor now and then.
        if (op == OP_DIV && $urandom_range(19) == 0) begin
          br = '0;
          bi = '0;
        end
        send_item(op, ar, ai, br, bi, 1'b0, '{0, 0, 0});
      end
    end
    in_ch.valid <= 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("complex_arithmetic_unit: match");
    else
      $display("complex_arithmetic_unit: mismatch");
    $finish;
  end

  initial begin
    #5ms;
    $display("complex_arithmetic_unit: mismatch");
    $finish;
  end
endmodule
